// ===== design/btlg_pkg.sv =====
// Shared types, constants and per-axis layout functions of the bitmap tile layout core.
package btlg_pkg;

   localparam int unsigned SizeWidth  = 14;
   localparam int unsigned LimitWidth = 13;
   localparam int unsigned IndexWidth = 13;
   localparam int unsigned PitchWidth = 12;
   localparam int unsigned OrgWidth   = IndexWidth + PitchWidth;
   localparam int unsigned LogWidth   = 4;
   localparam int unsigned ExtWidth   = 17;
   localparam int unsigned FracBits   = 16;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [SizeWidth-1:0]  BitmapWidthReset  = 14'd256;
   localparam logic [SizeWidth-1:0]  BitmapHeightReset = 14'd256;
   localparam logic [LimitWidth-1:0] TextureLimitReset = 13'd256;
   localparam logic [LimitWidth-1:0] LimitMin          = 13'd4;
   localparam logic [LimitWidth-1:0] LimitMax          = 13'd4096;

   typedef enum logic [1:0] {
      REG_BITMAP_WIDTH  = 2'd0,
      REG_BITMAP_HEIGHT = 2'd1,
      REG_TEXTURE_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [IndexWidth-1:0] tile_col;
      logic [IndexWidth-1:0] tile_row;
   } req_word_type;

   typedef struct packed {
      logic                  in_range;
      logic [LogWidth-1:0]   tex_width_log2;
      logic [LogWidth-1:0]   tex_height_log2;
      logic [SizeWidth-1:0]  load_left;
      logic [SizeWidth-1:0]  load_top;
      logic [SizeWidth-1:0]  load_right;
      logic [SizeWidth-1:0]  load_bottom;
      logic [1:0]            edge_pad;
      logic [PitchWidth-1:0] draw_width;
      logic [PitchWidth-1:0] draw_height;
      logic [ExtWidth-1:0]   u_extent;
      logic [ExtWidth-1:0]   v_extent;
   } rsp_word_type;

   // Layout of one axis of a tile.
   typedef struct packed {
      logic                  in_grid;
      logic [LogWidth-1:0]   lg;
      logic [SizeWidth-1:0]  lo;
      logic [SizeWidth-1:0]  hi;
      logic                  pad;
      logic [PitchWidth-1:0] draw;
      logic [ExtWidth-1:0]   ext;
   } axis_type;

   // Smallest k with 2^k >= len, for len of at least one.
   function automatic logic [LogWidth-1:0] ceil_log2(input logic [PitchWidth-1:0] len);
      logic [PitchWidth-1:0] m;
      logic [LogWidth-1:0]   k;
      m = len - PitchWidth'(1);
      k = '0;
      for (int i = 0; i < PitchWidth; i++) begin
         if (m[i]) begin
            k = LogWidth'(i + 1);
         end
      end
      return k;
   endfunction

   // Everything one axis needs once the tile origin is known.
   function automatic axis_type axis_layout(input logic [SizeWidth-1:0]  size,
                                            input logic [PitchWidth-1:0] pitch,
                                            input logic [OrgWidth-1:0]   org);
      axis_type               a;
      logic [SizeWidth-1:0]   org_s;
      logic [SizeWidth-1:0]   len_full;
      logic [PitchWidth-1:0]  len;
      logic [SizeWidth-1:0]   end_pos;
      logic [PitchWidth:0]    tex;
      logic [PitchWidth:0]    len_p1;
      logic [PitchWidth:0]    used;
      logic [PitchWidth+FracBits:0] scaled;
      org_s    = org[SizeWidth-1:0];
      len_full = size - org_s;
      len      = (len_full > SizeWidth'(pitch)) ? pitch : len_full[PitchWidth-1:0];
      end_pos  = org_s + SizeWidth'(len);
      a.in_grid = (org < OrgWidth'(size));
      a.lg     = ceil_log2(len);
      tex      = (PitchWidth+1)'(1) << a.lg;
      len_p1   = {1'b0, len} + (PitchWidth+1)'(1);
      used     = (len_p1 < tex) ? len_p1 : tex;
      scaled   = {used, FracBits'(0)} >> a.lg;
      a.ext    = scaled[ExtWidth-1:0];
      a.lo     = (org_s != '0) ? org_s - SizeWidth'(1) : '0;
      a.hi     = (end_pos < size) ? end_pos + SizeWidth'(1) : end_pos;
      a.pad    = (org_s == '0);
      a.draw   = len;
      return a;
   endfunction

endpackage

// ===== design/bitmap_tile_layout_with_gutter_core.sv =====
// Top level of the bitmap tile layout core: config registers, three-stage pipeline, checks.
//
// The core cuts a bitmap of the configured width by height in pixels into tiles whose pitch is
// texture_limit minus two (the limit is clamped to 4..4096 first), and for each requested
// tile column and row returns one word with the power-of-two texture size as log2, the
// source load rectangle widened by one pixel toward inner neighbors, the left and top
// padding flags, the drawn tile size and the used texture fraction in unsigned Q1.16.
// A tile whose origin lies at or beyond the bitmap edge gives in_range low and all other
// fields zero. It takes one word per clock while req_stall is low and passes each accepted
// word through its stages: the first stage is the input register, the second holds the tile
// origins (one 13 by 12 bit multiply per axis), and the third is the result register fed
// by the compare, subtract, priority encoder and shift of both axes. Each stage moves on
// whenever the stage after it is empty or moving, so a stalled result keeps its place
// while up to two more words are taken in behind it. Registers are written through the
// APB-style port at byte addresses 0 (width), 4 (height) and 8 (texture limit), and must
// only be changed while no word is inside the pipeline.
module bitmap_tile_layout_with_gutter_core
   import btlg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_word_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_word_type            rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // Configuration registers.
   logic [SizeWidth-1:0]  src_width_ff;
   logic [SizeWidth-1:0]  src_height_ff;
   logic [LimitWidth-1:0] texture_limit_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= BitmapWidthReset;
         src_height_ff    <= BitmapHeightReset;
         texture_limit_ff <= TextureLimitReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_BITMAP_WIDTH:  src_width_ff     <= pwdata[SizeWidth-1:0];
            REG_BITMAP_HEIGHT: src_height_ff    <= pwdata[SizeWidth-1:0];
            REG_TEXTURE_LIMIT: texture_limit_ff <= pwdata[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BITMAP_WIDTH:  prdata = CsrDataWidth'(src_width_ff);
         REG_BITMAP_HEIGHT: prdata = CsrDataWidth'(src_height_ff);
         REG_TEXTURE_LIMIT: prdata = CsrDataWidth'(texture_limit_ff);
         default:           prdata = '0;
      endcase
   end

   // Pitch = clamped limit - 2. Users keep it put while words are in flight; not enforced.
   logic [LimitWidth-1:0] limit_clamped;
   logic [LimitWidth-1:0] pitch_full;
   logic [PitchWidth-1:0] pitch;

   always_comb begin
      if (texture_limit_ff < LimitMin) begin
         limit_clamped = LimitMin;
      end else if (texture_limit_ff > LimitMax) begin
         limit_clamped = LimitMax;
      end else begin
         limit_clamped = texture_limit_ff;
      end
      pitch_full = limit_clamped - LimitWidth'(2);
      pitch      = pitch_full[PitchWidth-1:0];
   end

   // Pipeline flow control: a stage loads when it is empty or its contents move on.
   logic stage1_valid_ff, stage1_valid_in;
   logic stage2_valid_ff, stage2_valid_in;
   logic rsp_valid_ff,    rsp_valid_in;
   logic advance1, advance2, advance3;

   assign advance3 = !rsp_valid_ff || !rsp_stall;
   assign advance2 = !stage2_valid_ff || advance3;
   assign advance1 = !stage1_valid_ff || advance2;
   assign req_stall = !advance1;

   assign stage1_valid_in = advance1 ? req_valid       : stage1_valid_ff;
   assign stage2_valid_in = advance2 ? stage1_valid_ff : stage2_valid_ff;
   assign rsp_valid_in    = advance3 ? stage2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         stage2_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stage1_valid_ff <= stage1_valid_in;
         stage2_valid_ff <= stage2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Stage one: input register.
   req_word_type req_word_ff, req_word_in;

   assign req_word_in = (req_valid && advance1) ? req_data : req_word_ff;

   always_ff @(posedge clock) begin
      req_word_ff <= req_word_in;
   end

   // Stage two: tile origins, one multiply per axis.
   logic [OrgWidth-1:0] org_x_ff, org_x_in;
   logic [OrgWidth-1:0] org_y_ff, org_y_in;
   logic                load2;

   assign load2    = stage1_valid_ff && advance2;
   assign org_x_in = load2 ? OrgWidth'(req_word_ff.tile_col) * OrgWidth'(pitch) : org_x_ff;
   assign org_y_in = load2 ? OrgWidth'(req_word_ff.tile_row) * OrgWidth'(pitch) : org_y_ff;

   always_ff @(posedge clock) begin
      org_x_ff <= org_x_in;
      org_y_ff <= org_y_in;
   end

   // Stage three: per-axis layout and the result register.
   axis_type     ax;
   axis_type     ay;
   rsp_word_type rsp_word;
   rsp_word_type rsp_word_ff, rsp_word_in;

   always_comb begin
      ax = axis_layout(src_width_ff, pitch, org_x_ff);
      ay = axis_layout(src_height_ff, pitch, org_y_ff);
      rsp_word = '0;
      if (ax.in_grid && ay.in_grid) begin
         rsp_word.in_range        = 1'b1;
         rsp_word.tex_width_log2  = ax.lg;
         rsp_word.tex_height_log2 = ay.lg;
         rsp_word.load_left       = ax.lo;
         rsp_word.load_top        = ay.lo;
         rsp_word.load_right      = ax.hi;
         rsp_word.load_bottom     = ay.hi;
         rsp_word.edge_pad        = {ay.pad, ax.pad};
         rsp_word.draw_width      = ax.draw;
         rsp_word.draw_height     = ay.draw;
         rsp_word.u_extent        = ax.ext;
         rsp_word.v_extent        = ay.ext;
      end
   end

   assign rsp_word_in = (stage2_valid_ff && advance3) ? rsp_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // An out-of-range tile carries nothing but zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_range |->
         rsp_data.load_right == '0 && rsp_data.load_bottom == '0 &&
         rsp_data.u_extent == '0 && rsp_data.edge_pad == '0)
      else $error("out-of-range word has nonzero fields");

   // An in-range tile has a nonempty load rectangle and a nonzero draw size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_range |->
         rsp_data.load_left < rsp_data.load_right &&
         rsp_data.load_top < rsp_data.load_bottom &&
         rsp_data.draw_width != '0 && rsp_data.draw_height != '0)
      else $error("in-range word has an empty rectangle");

   // The padding flags mark exactly the tiles whose load rectangle starts at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_range |->
         rsp_data.edge_pad[0] == (rsp_data.load_left == '0) &&
         rsp_data.edge_pad[1] == (rsp_data.load_top == '0))
      else $error("edge padding flags disagree with load origin");

   // The used texture fraction of an in-range tile lies in (0, 1].
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_range |->
         rsp_data.u_extent != '0 && rsp_data.u_extent <= ExtWidth'(1 << FracBits) &&
         rsp_data.v_extent != '0 && rsp_data.v_extent <= ExtWidth'(1 << FracBits))
      else $error("texture fraction out of range");

endmodule
